// File: src/wpe_pkg.sv
// Shared constants, opcodes and controller/datapath command and status types.
package wpe_pkg;

  localparam int BUCKETS_DEF     = 180;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAME_W         = 32;
  localparam int OP_W            = 2;
  localparam int IDX_W           = 8;
  localparam int LEVEL_W         = 16;

  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  typedef struct packed {
    logic take;            // input transfer this cycle
    logic sweep_wr;        // zero one bucket entry
    logic mul_load;        // register frame_count * BUCKETS
    logic bucket_clamp;    // bucket = last
    logic div_load_bkt;    // start bucket division
    logic div_load_lvl;    // start level division
    logic bucket_from_div; // take clamped quotient as bucket
    logic ram_rd;          // read bucket entry
    logic frame_commit;    // fold frame peak into store
    logic lvl_from_ram;    // raw level
    logic lvl_from_div;    // normalized level
    logic out_load;        // load result register
  } wpe_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            frame_end;
    logic            tf_zero;
    logic            sweep_last;
    logic            bucket_over;
    logic            div_busy;
    logic            norm;
    logic            out_free;
  } wpe_sts_t;

endpackage

// File: src/wpe_if.sv
// Input item and result channel interfaces.
interface wpe_in_if import wpe_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               opcode;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          frame_end;
  logic [IDX_W-1:0]              bucket_index;

  modport source(output valid, opcode, sample, frame_end, bucket_index, input ready);
  modport sink(input valid, opcode, sample, frame_end, bucket_index, output ready);
endinterface

interface wpe_out_if import wpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [IDX_W-1:0]   bucket_number;

  modport source(output valid, level, bucket_number, input ready);
  modport sink(input valid, level, bucket_number, output ready);
endinterface

// File: src/waveform_peak_envelope_unit.sv
// Top level of the waveform peak envelope: controller, datapath and ports.
//
// Builds a peak overview of an audio stream in BUCKETS buckets. Each item is
// one transfer on the input channel: a sample (with frame_end on the last
// channel sample of a frame), a bucket read, or a clear. A sample without a
// frame end needs no step beyond its transfer. At a frame end the bucket
// position frame_count*BUCKETS/track_frames is found on the shared restoring
// divider, one quotient bit per cycle, followed by a read-modify-write of the
// bucket RAM. A read returns the raw level when the overall peak is at or
// below 0.01 full scale, else the divider produces the level scaled so the
// overall peak reads as 0.95, rounded half up. Results go to an output
// register, so samples keep flowing while a result waits for its transfer; a
// further read waits until that register can be reloaded. After reset and
// after each clear the bucket RAM is zeroed by a sweep over all BUCKETS
// entries, during which no item is taken; track_frames writes are taken at
// any time and only while idle are they meaningful. With track_frames at
// zero, frame ends record nothing. Bucket reads past the end return the last
// bucket.
module waveform_peak_envelope_unit import wpe_pkg::*; #(
  parameter int BUCKETS     = BUCKETS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [FRAME_W-1:0] cfg_wr_data,
  wpe_in_if.sink             item,
  wpe_out_if.source          result
);

  wpe_cmd_t cmd;
  wpe_sts_t sts;

  // sequencing: one item in flight, result register decoupled
  wpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item.valid),
    .item_ready(item.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, arithmetic and the result register
  wpe_datapath #(
    .BUCKETS    (BUCKETS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (item.opcode),
    .sample       (item.sample),
    .frame_end    (item.frame_end),
    .bucket_index (item.bucket_index),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .level        (result.level),
    .bucket_number(result.bucket_number)
  );

endmodule

// File: src/wpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 180
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/wpe_div.sv
// Restoring divider, one quotient bit per cycle, quotient bits known to fit.
module wpe_div #(
  parameter int DVS_W = 32,
  parameter int QW    = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [DVS_W-1:0]          r_init,
  input  logic [QW-1:0]             dq_init,
  input  logic [DVS_W-1:0]          divisor,
  input  logic [$clog2(QW+1)-1:0]   steps,
  output logic                      busy,
  output logic [QW-1:0]             quotient
);

  localparam int SW = $clog2(QW + 1);

  logic [DVS_W-1:0] r;
  logic [QW-1:0]    dq;
  logic [DVS_W-1:0] d;
  logic [SW-1:0]    cnt;
  logic [DVS_W:0]   rs;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    rs   = {r, dq[QW-1]};
    ge   = rs >= {1'b0, d};
    diff = rs - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == SW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder stays below the divisor, so the low DVS_W bits hold it
  always_ff @(posedge clk) begin
    if (load) begin
      r  <= r_init;
      dq <= dq_init;
      d  <= divisor;
    end else if (busy) begin
      r  <= ge ? diff[DVS_W-1:0] : rs[DVS_W-1:0];
      dq <= {dq[QW-2:0], ge};
    end
  end

  assign quotient = dq;

endmodule

// File: src/wpe_datapath.sv
// Datapath: peak tracking, bucket store, shared divider and result register.
module wpe_datapath import wpe_pkg::*; #(
  parameter int BUCKETS     = BUCKETS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [FRAME_W-1:0]            cfg_wr_data,
  input  wpe_cmd_t                      cmd,
  output wpe_sts_t                      sts,
  input  logic [OP_W-1:0]               opcode,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          frame_end,
  input  logic [IDX_W-1:0]              bucket_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [LEVEL_W-1:0]            level,
  output logic [IDX_W-1:0]              bucket_number
);

  localparam int SB     = SAMPLE_BITS;
  localparam int QB     = $clog2(BUCKETS);
  localparam int QW     = imax(QB, SB);
  localparam int CW     = imax(IDX_W, QB);
  localparam int PW     = FRAME_W + QB;
  localparam int NW     = 2 * SB + 6;
  localparam int LDW    = SB + 6;
  localparam int DVS_W  = imax(FRAME_W, LDW);
  localparam int SW     = $clog2(QW + 1);
  // 0.95 with round-half-up: (v*38*F + 20m) / (40m); 0.01 test: m*100 > F
  localparam int RND_MUL  = 38;
  localparam int HALF_DEN = 20;
  localparam int DEN_MUL  = 40;
  localparam int NORM_MUL = 100;
  localparam logic [LDW-1:0] FULL = LDW'(1) << (SB - 1);

  logic [FRAME_W-1:0] track_frames;
  logic [FRAME_W-1:0] frame_count;
  logic [SB-1:0]      frame_peak;
  logic [SB-1:0]      overall_peak;
  logic [QB-1:0]      sweep_cnt;
  logic [QB-1:0]      bucket;
  logic [PW-1:0]      product;
  logic [SB-1:0]      lvl;

  logic [SB-1:0]      smp_u;
  logic [SB-1:0]      mag;
  logic [SB-1:0]      peak_max;
  logic [CW-1:0]      idx_w;
  logic [CW-1:0]      idx_c;
  logic [CW-1:0]      bkt_w;
  logic [SB-1:0]      ram_rdata;
  logic               ram_we;
  logic [QB-1:0]      ram_waddr;
  logic [SB-1:0]      ram_wdata;
  logic [NW-1:0]      nlv;
  logic [DVS_W-1:0]   div_r;
  logic [QW-1:0]      div_dq;
  logic [DVS_W-1:0]   div_d;
  logic [SW-1:0]      div_steps;
  logic               div_busy;
  logic [QW-1:0]      div_q;
  logic [QB-1:0]      q_bk;
  logic [QB-1:0]      q_bk_c;
  logic [SB+LEVEL_W-1:0] lvl_w;

  always_comb begin
    smp_u    = sample;
    mag      = smp_u[SB-1] ? SB'(~smp_u + 1'b1) : smp_u;
    peak_max = (mag > frame_peak) ? mag : frame_peak;
    idx_w    = CW'(bucket_index);
    idx_c    = (idx_w > CW'(BUCKETS - 1)) ? CW'(BUCKETS - 1) : idx_w;
    bkt_w    = CW'(bucket);
    q_bk     = div_q[QB-1:0];
    q_bk_c   = (q_bk > QB'(BUCKETS - 1)) ? QB'(BUCKETS - 1) : q_bk;
    lvl_w    = (SB + LEVEL_W)'(lvl);
    nlv      = ((NW'(ram_rdata) * NW'(RND_MUL)) << (SB - 1))
             + NW'(overall_peak) * NW'(HALF_DEN);
  end

  // divider operands: quotient bits are known to fit, so the remainder
  // starts from the dividend's upper part
  always_comb begin
    if (cmd.div_load_lvl) begin
      div_r     = DVS_W'(nlv >> SB);
      div_dq    = QW'(nlv[SB-1:0]) << (QW - SB);
      div_d     = DVS_W'(overall_peak) * DVS_W'(DEN_MUL);
      div_steps = SW'(SB);
    end else begin
      div_r     = DVS_W'(product >> QB);
      div_dq    = QW'(product[QB-1:0]) << (QW - QB);
      div_d     = DVS_W'(track_frames);
      div_steps = SW'(QB);
    end
  end

  always_comb begin
    ram_we    = cmd.sweep_wr | (cmd.frame_commit & (frame_peak > ram_rdata));
    ram_waddr = cmd.sweep_wr ? sweep_cnt : bucket;
    ram_wdata = cmd.sweep_wr ? '0 : frame_peak;
  end

  always_comb begin
    sts.opcode      = opcode;
    sts.frame_end   = frame_end;
    sts.tf_zero     = (track_frames == '0);
    sts.sweep_last  = (sweep_cnt == QB'(BUCKETS - 1));
    sts.bucket_over = (product >= {track_frames, {QB{1'b0}}});
    sts.div_busy    = div_busy;
    sts.norm        = (LDW'(overall_peak) * LDW'(NORM_MUL)) > FULL;
    sts.out_free    = !out_valid || out_ready;
  end

  wpe_ram #(
    .WIDTH(SB),
    .DEPTH(BUCKETS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.ram_rd),
    .raddr(bucket),
    .rdata(ram_rdata)
  );

  wpe_div #(
    .DVS_W(DVS_W),
    .QW   (QW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .load    (cmd.div_load_bkt | cmd.div_load_lvl),
    .r_init  (div_r),
    .dq_init (div_dq),
    .divisor (div_d),
    .steps   (div_steps),
    .busy    (div_busy),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      track_frames <= '0;
      frame_count  <= '0;
      frame_peak   <= '0;
      overall_peak <= '0;
      sweep_cnt    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        track_frames <= cfg_wr_data;
      end
      if (cmd.take) begin
        case (opcode)
          OP_SAMPLE: begin
            frame_peak <= (frame_end && track_frames == '0) ? '0 : peak_max;
          end
          OP_CLEAR: begin
            frame_count  <= '0;
            frame_peak   <= '0;
            overall_peak <= '0;
            sweep_cnt    <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.sweep_wr) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
      if (cmd.frame_commit) begin
        if (frame_peak > overall_peak) begin
          overall_peak <= frame_peak;
        end
        if (frame_count != '1) begin
          frame_count <= frame_count + 1'b1;
        end
        frame_peak <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && opcode == OP_READ) begin
      bucket <= idx_c[QB-1:0];
    end
    if (cmd.bucket_clamp) begin
      bucket <= QB'(BUCKETS - 1);
    end
    if (cmd.bucket_from_div) begin
      bucket <= q_bk_c;
    end
    if (cmd.mul_load) begin
      product <= PW'(frame_count) * PW'(BUCKETS);
    end
    if (cmd.lvl_from_ram) begin
      lvl <= ram_rdata;
    end
    if (cmd.lvl_from_div) begin
      lvl <= div_q[SB-1:0];
    end
    if (cmd.out_load) begin
      level         <= lvl_w[LEVEL_W-1:0];
      bucket_number <= bkt_w[IDX_W-1:0];
    end
  end

endmodule

// File: src/wpe_ctrl.sv
// Controller state machine sequencing samples, frame ends, reads and clears.
module wpe_ctrl import wpe_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  wpe_sts_t sts,
  output wpe_cmd_t cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_BMUL  = 4'd2;
  localparam logic [3:0] S_BCHK  = 4'd3;
  localparam logic [3:0] S_BDIV  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_WR    = 4'd6;
  localparam logic [3:0] S_LRD   = 4'd7;
  localparam logic [3:0] S_LCHK  = 4'd8;
  localparam logic [3:0] S_LDIV  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.take = 1'b1;
          case (sts.opcode)
            OP_SAMPLE: begin
              if (sts.frame_end && !sts.tf_zero) begin
                state_next = S_BMUL;
              end
            end
            OP_READ:  state_next = S_LRD;
            OP_CLEAR: state_next = S_CLEAR;
            default:  ;
          endcase
        end
      end
      S_BMUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_BCHK;
      end
      S_BCHK: begin
        if (sts.bucket_over) begin
          cmd.bucket_clamp = 1'b1;
          state_next       = S_RD;
        end else begin
          cmd.div_load_bkt = 1'b1;
          state_next       = S_BDIV;
        end
      end
      S_BDIV: begin
        if (!sts.div_busy) begin
          cmd.bucket_from_div = 1'b1;
          state_next          = S_RD;
        end
      end
      S_RD: begin
        cmd.ram_rd = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.frame_commit = 1'b1;
        state_next       = S_IDLE;
      end
      S_LRD: begin
        cmd.ram_rd = 1'b1;
        state_next = S_LCHK;
      end
      S_LCHK: begin
        if (sts.norm) begin
          cmd.div_load_lvl = 1'b1;
          state_next       = S_LDIV;
        end else begin
          cmd.lvl_from_ram = 1'b1;
          state_next       = S_OUT;
        end
      end
      S_LDIV: begin
        if (!sts.div_busy) begin
          cmd.lvl_from_div = 1'b1;
          state_next       = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
